FILE: design/awc_pkg.sv
// Shared constants, types and state codes of the ADC window averager.
`default_nettype none

package awc_pkg;

    localparam int CHANNELS   = 11;
    localparam int WINDOW     = 10;
    localparam int HALF_SCALE = 2048;
    localparam int MAX_SCALE  = 4095;

    localparam int SMP_W  = 12;
    localparam int CH_W   = 4;
    localparam int PIDX_W = 2;
    localparam int FS_W   = 14;
    localparam int NORM_W = 15;

    localparam logic [FS_W-1:0] FS_RESET = 14'd10000;
    localparam int NORM_MAX = 16383;

    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_DEPTH = CHANNELS * WINDOW;
    localparam int WA_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int SUM_W     = $clog2((2**SMP_W - 1) * WINDOW + 1);

    // sum / WINDOW by reciprocal, one correction step afterwards
    localparam logic [SUM_W:0] AVG_RECIP = (SUM_W+1)'((2**SUM_W) / WINDOW);

    // calibration divider: quotient never exceeds HALF_SCALE
    localparam int QUO_W  = $clog2(HALF_SCALE + 1);
    localparam int DNUM_W = SMP_W + QUO_W;
    localparam int QCNT_W = $clog2(QUO_W + 1);

    // normalize: magnitude * full_scale / HALF_SCALE by reciprocal
    localparam int NP_W = SMP_W + FS_W;
    localparam logic [NP_W-1:0] NORM_RECIP = NP_W'((2**NP_W) / HALF_SCALE);

    localparam logic ACT_SAMPLE    = 1'b0;
    localparam logic ACT_CAL_WRITE = 1'b1;

    localparam logic [PIDX_W-1:0] PT_LO   = 2'd0;
    localparam logic [PIDX_W-1:0] PT_MID  = 2'd1;
    localparam logic [PIDX_W-1:0] PT_HI   = 2'd2;
    localparam logic [PIDX_W-1:0] PT_NONE = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CH_RD,
        ST_WIN_RD,
        ST_AVG_MUL,
        ST_AVG_FIX,
        ST_CAL,
        ST_DIV,
        ST_NRM_MUL,
        ST_NRM_RCP,
        ST_NRM_FIX,
        ST_EMIT
    } awc_state_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             analog;
        logic [SMP_W-1:0] pt_lo;
        logic [SMP_W-1:0] pt_mid;
        logic [SMP_W-1:0] pt_hi;
        logic [SUM_W-1:0] sum;
    } chan_entry_t;

    typedef struct packed {
        logic             en;
        logic [WA_W-1:0]  addr;
        logic [SMP_W-1:0] data;
    } win_wr_t;

    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] addr;
        chan_entry_t         data;
    } chan_wr_t;

endpackage

`default_nettype wire

FILE: design/awc_ifs.sv
// Item and result channel interfaces of the ADC window averager.
`default_nettype none

interface awc_item_if import awc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [CH_W-1:0]   channel;
    logic [SMP_W-1:0]  sample;
    logic [PIDX_W-1:0] point_index;
    logic [SMP_W-1:0]  point_value;
    logic              analog_enable;

    modport source (
        output valid, action, channel, sample, point_index, point_value, analog_enable,
        input  ready
    );
    modport sink (
        input  valid, action, channel, sample, point_index, point_value, analog_enable,
        output ready
    );
endinterface

interface awc_result_if import awc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          out_channel;
    logic [SMP_W-1:0]         raw_average;
    logic [SMP_W-1:0]         calibrated;
    logic signed [NORM_W-1:0] normalized;
    logic                     is_analog;

    modport source (
        output valid, out_channel, raw_average, calibrated, normalized, is_analog,
        input  ready
    );
    modport sink (
        input  valid, out_channel, raw_average, calibrated, normalized, is_analog,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/awc_store.sv
// Window sample memory and per-channel state memory, registered reads.
`default_nettype none

module awc_store import awc_pkg::*; (
    input  wire logic                clk,
    input  wire win_wr_t             win_wr,
    input  wire logic [WA_W-1:0]     win_raddr,
    output logic [SMP_W-1:0]         win_rdata,
    input  wire chan_wr_t            chan_wr,
    input  wire logic [CH_IDX_W-1:0] chan_raddr,
    output chan_entry_t              chan_rdata
);

    logic [SMP_W-1:0] win_mem [WIN_DEPTH];
    chan_entry_t      chan_mem [CHANNELS];

    always_ff @(posedge clk)
    begin
        if (win_wr.en)
        begin
            win_mem[win_wr.addr] <= win_wr.data;
        end
        win_rdata <= win_mem[win_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (chan_wr.en)
        begin
            chan_mem[chan_wr.addr] <= chan_wr.data;
        end
        chan_rdata <= chan_mem[chan_raddr];
    end

endmodule

`default_nettype wire

FILE: design/awc_frac_div.sv
// Restoring divider, one quotient bit per cycle, for the calibration slope.
`default_nettype none

module awc_frac_div import awc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DNUM_W-1:0] num,
    input  wire logic [SMP_W-1:0]  den,
    output logic                   done,
    output logic [QUO_W-1:0]       quot
);

    logic              busy_reg;
    logic              done_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [SMP_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  sh_reg;
    logic [SMP_W-1:0]  den_reg;

    logic [SMP_W:0]    trial;
    logic [SMP_W:0]    diff;
    logic              qbit;

    // remainder stays below den, so the upper numerator bits start it directly
    assign trial = {rem_reg, sh_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == QCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[DNUM_W-1:QUO_W];
            sh_reg  <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[SMP_W-1:0] : trial[SMP_W-1:0];
            sh_reg  <= {sh_reg[QUO_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

`default_nettype wire

FILE: design/adc_window_average_three_point_calibrate_top.sv
// Top level: per-channel window averager with three-point calibration.
//
//  port     | dir  | handshake     | contents
//  ---------+------+---------------+------------------------------------------
//  item     | in   | valid/ready   | sample or calibration-point write
//  result   | out  | valid/ready   | channel, average, calibrated, normalized
//  cfg_*    | in   | write enable  | full_scale
//
// One item at a time. Sample item: the channel entry and window slot are read, the
// window sum is updated and averaged; a plain channel then loads the result register,
// an analog one first calibrates (a fixed branch, or interpolation by the bit-serial
// slope divider) and normalizes. The sequencer returns to idle before the next accept.
// Calibration write: channel entry updated, no result. After reset a clearing pass
// zeroes both memories; no item is taken meanwhile. A pending result does not block
// intake; only the final load waits for the result register to empty.
`default_nettype none

module adc_window_average_three_point_calibrate_top import awc_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    awc_item_if.sink             item,
    awc_result_if.source         result,
    input  wire logic            cfg_we,
    input  wire logic [FS_W-1:0] cfg_wdata
);

    awc_state_t state_reg, state_next;

    logic [WA_W-1:0]   clr_cnt_reg;
    logic [FS_W-1:0]   fs_reg;

    logic              act_reg;
    logic [CH_IDX_W-1:0] ch_reg;
    logic [SMP_W-1:0]  smp_reg;
    logic [PIDX_W-1:0] pidx_reg;
    logic [SMP_W-1:0]  pval_reg;
    logic              aen_reg;

    chan_entry_t       entry_reg;
    logic [WA_W-1:0]   waddr_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  avg_q_reg;
    logic [SMP_W-1:0]  avg_reg;
    logic [SMP_W-1:0]  cal_reg;
    logic              upper_reg;
    logic              neg_reg;
    logic [NP_W-1:0]   np_reg;
    logic [NP_W-1:0]   nq_reg;
    logic [NORM_W-1:0] nrm_reg;

    logic                     out_valid_reg;
    logic [CH_W-1:0]          out_ch_reg;
    logic [SMP_W-1:0]         out_avg_reg;
    logic [SMP_W-1:0]         out_cal_reg;
    logic signed [NORM_W-1:0] out_nrm_reg;
    logic                     out_an_reg;

    // control
    logic                item_rdy;
    logic                item_take;
    logic                out_load;
    logic                div_start;
    win_wr_t             win_wr;
    chan_wr_t            chan_wr;
    logic [CH_IDX_W-1:0] chan_raddr;
    logic [WA_W-1:0]     win_addr_c;
    logic [SMP_W-1:0]    win_rdata;
    chan_entry_t         chan_rdata;
    chan_entry_t         cal_entry;

    // datapath
    logic [SUM_W-1:0]    sum_next;
    logic [POS_W-1:0]    pos_next;
    logic [2*SUM_W:0]    avg_prod;
    logic [SUM_W-1:0]    avg_qw;
    logic [SUM_W-1:0]    avg_rem;
    logic [SUM_W-1:0]    avg_next;

    logic                cal_direct;
    logic [SMP_W-1:0]    cal_val;
    logic                upper_c;
    logic [SMP_W-1:0]    dnum_d;
    logic [SMP_W-1:0]    dden;
    logic [DNUM_W-1:0]   div_num;
    logic                div_done;
    logic [QUO_W-1:0]    div_quot;
    logic [SMP_W:0]      cal_sum;
    logic [SMP_W-1:0]    cal_next;

    logic                neg_c;
    logic [SMP_W-1:0]    mag_c;
    logic [2*NP_W-1:0]   nrm_prod;
    logic [NP_W-1:0]     nrm_qh;
    logic [NP_W-1:0]     nrm_rem;
    logic [NP_W-1:0]     nrm_q;
    logic [NORM_W-1:0]   nrm_mag;
    logic [NORM_W-1:0]   nrm_next;

    awc_store u_store (
        .clk        (clk),
        .win_wr     (win_wr),
        .win_raddr  (win_addr_c),
        .win_rdata  (win_rdata),
        .chan_wr    (chan_wr),
        .chan_raddr (chan_raddr),
        .chan_rdata (chan_rdata)
    );

    awc_frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dden),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign item_take  = item.valid && item_rdy;
    assign chan_raddr = item.channel[CH_IDX_W-1:0];
    assign win_addr_c = WA_W'(ch_reg) * WA_W'(WINDOW) + WA_W'(chan_rdata.pos);

    // ---------------- per-channel updates ----------------
    always_comb
    begin
        cal_entry        = chan_rdata;
        cal_entry.analog = aen_reg;
        case (pidx_reg)
            PT_LO:   cal_entry.pt_lo  = pval_reg;
            PT_MID:  cal_entry.pt_mid = pval_reg;
            PT_HI:   cal_entry.pt_hi  = pval_reg;
            default: cal_entry.analog = chan_rdata.analog;
        endcase
    end

    assign sum_next = entry_reg.sum - SUM_W'(win_rdata) + SUM_W'(smp_reg);
    assign pos_next = (entry_reg.pos == POS_W'(WINDOW - 1)) ? '0 : entry_reg.pos + 1'b1;

    // ---------------- average ----------------
    assign avg_prod = (2*SUM_W+1)'(sum_reg) * (2*SUM_W+1)'(AVG_RECIP);
    assign avg_qw   = SUM_W'(avg_q_reg * SUM_W'(WINDOW));
    assign avg_rem  = sum_reg - avg_qw;
    assign avg_next = (avg_rem >= SUM_W'(WINDOW)) ? avg_q_reg + 1'b1 : avg_q_reg;

    // ---------------- calibration branch ----------------
    always_comb
    begin
        cal_direct = 1'b1;
        cal_val    = '0;
        upper_c    = 1'b0;
        dnum_d     = avg_reg - entry_reg.pt_lo;
        dden       = entry_reg.pt_mid - entry_reg.pt_lo;
        if (avg_reg < entry_reg.pt_lo)
        begin
            cal_val = '0;
        end
        else if (avg_reg > entry_reg.pt_hi)
        begin
            cal_val = SMP_W'(MAX_SCALE);
        end
        else if (avg_reg == entry_reg.pt_mid)
        begin
            cal_val = SMP_W'(HALF_SCALE);
        end
        else if (avg_reg > entry_reg.pt_mid)
        begin
            cal_direct = 1'b0;
            upper_c    = 1'b1;
            dnum_d     = avg_reg - entry_reg.pt_mid;
            dden       = entry_reg.pt_hi - entry_reg.pt_mid;
        end
        else
        begin
            cal_direct = 1'b0;
        end
    end

    assign div_num  = DNUM_W'(dnum_d) * DNUM_W'(HALF_SCALE);
    assign cal_sum  = upper_reg ? (SMP_W+1)'(HALF_SCALE) + (SMP_W+1)'(div_quot)
                                : (SMP_W+1)'(div_quot);
    assign cal_next = (cal_sum > (SMP_W+1)'(MAX_SCALE)) ? SMP_W'(MAX_SCALE)
                                                        : cal_sum[SMP_W-1:0];

    // ---------------- normalize ----------------
    assign neg_c    = cal_reg < SMP_W'(HALF_SCALE);
    assign mag_c    = neg_c ? SMP_W'(HALF_SCALE) - cal_reg : cal_reg - SMP_W'(HALF_SCALE);
    assign nrm_prod = (2*NP_W)'(np_reg) * (2*NP_W)'(NORM_RECIP);
    assign nrm_qh   = NP_W'(nq_reg * NP_W'(HALF_SCALE));
    assign nrm_rem  = np_reg - nrm_qh;
    assign nrm_q    = (nrm_rem >= NP_W'(HALF_SCALE)) ? nq_reg + 1'b1 : nq_reg;
    assign nrm_mag  = (nrm_q > NP_W'(NORM_MAX)) ? NORM_W'(NORM_MAX) : NORM_W'(nrm_q);
    assign nrm_next = neg_reg ? ~nrm_mag + 1'b1 : nrm_mag;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_rdy   = 1'b0;
        out_load   = 1'b0;
        div_start  = 1'b0;
        win_wr     = '0;
        chan_wr    = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                win_wr.en   = 1'b1;
                win_wr.addr = clr_cnt_reg;
                if ({1'b0, clr_cnt_reg} < (WA_W+1)'(CHANNELS))
                begin
                    chan_wr.en   = 1'b1;
                    chan_wr.addr = clr_cnt_reg[CH_IDX_W-1:0];
                end
                if (clr_cnt_reg == WA_W'(WIN_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_rdy = 1'b1;
                // out-of-range channels and calibration writes to point index three are dropped here
                if (item.valid && ({1'b0, item.channel} < (CH_W+1)'(CHANNELS))
                    && !(item.action == ACT_CAL_WRITE && item.point_index == PT_NONE))
                begin
                    state_next = ST_CH_RD;
                end
            end
            ST_CH_RD:
            begin
                if (act_reg == ACT_CAL_WRITE)
                begin
                    chan_wr.en   = 1'b1;
                    chan_wr.addr = ch_reg;
                    chan_wr.data = cal_entry;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WIN_RD;
                end
            end
            ST_WIN_RD:
            begin
                win_wr.en         = 1'b1;
                win_wr.addr       = waddr_reg;
                win_wr.data       = smp_reg;
                chan_wr.en        = 1'b1;
                chan_wr.addr      = ch_reg;
                chan_wr.data      = entry_reg;
                chan_wr.data.pos  = pos_next;
                chan_wr.data.sum  = sum_next;
                state_next        = ST_AVG_MUL;
            end
            ST_AVG_MUL:
            begin
                state_next = ST_AVG_FIX;
            end
            ST_AVG_FIX:
            begin
                state_next = entry_reg.analog ? ST_CAL : ST_EMIT;
            end
            ST_CAL:
            begin
                if (cal_direct)
                begin
                    state_next = ST_NRM_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_NRM_MUL;
                end
            end
            ST_NRM_MUL:
            begin
                state_next = ST_NRM_RCP;
            end
            ST_NRM_RCP:
            begin
                state_next = ST_NRM_FIX;
            end
            ST_NRM_FIX:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    act_reg  <= item.action;
                    ch_reg   <= item.channel[CH_IDX_W-1:0];
                    smp_reg  <= item.sample;
                    pidx_reg <= item.point_index;
                    pval_reg <= item.point_value;
                    aen_reg  <= item.analog_enable;
                end
            end
            ST_CH_RD:
            begin
                entry_reg <= chan_rdata;
                waddr_reg <= win_addr_c;
            end
            ST_WIN_RD:
            begin
                sum_reg <= sum_next;
            end
            ST_AVG_MUL:
            begin
                avg_q_reg <= avg_prod[2*SUM_W-1:SUM_W];
            end
            ST_AVG_FIX:
            begin
                avg_reg <= avg_next[SMP_W-1:0];
                cal_reg <= '0;
                nrm_reg <= '0;
            end
            ST_CAL:
            begin
                cal_reg   <= cal_val;
                upper_reg <= upper_c;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    cal_reg <= cal_next;
                end
            end
            ST_NRM_MUL:
            begin
                np_reg  <= NP_W'(mag_c) * NP_W'(fs_reg);
                neg_reg <= neg_c;
            end
            ST_NRM_RCP:
            begin
                nq_reg <= nrm_prod[2*NP_W-1:NP_W];
            end
            ST_NRM_FIX:
            begin
                nrm_reg <= nrm_next;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FS_RESET;
        end
        else if (cfg_we)
        begin
            fs_reg <= cfg_wdata;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch_reg  <= CH_W'(ch_reg);
            out_avg_reg <= avg_reg;
            out_cal_reg <= cal_reg;
            out_nrm_reg <= $signed(nrm_reg);
            out_an_reg  <= entry_reg.analog;
        end
    end

    assign item.ready         = item_rdy;
    assign result.valid       = out_valid_reg;
    assign result.out_channel = out_ch_reg;
    assign result.raw_average = out_avg_reg;
    assign result.calibrated  = out_cal_reg;
    assign result.normalized  = out_nrm_reg;
    assign result.is_analog   = out_an_reg;

endmodule

`default_nettype wire

FILE: test/adc_window_average_three_point_calibrate_top_tb.sv
// Testbench for the ADC window averager: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module adc_window_average_three_point_calibrate_top_tb;
    import awc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_WAIT       = 17;
    localparam int PHASE_ITEMS    = 200;

    typedef struct {
        logic              action;
        logic [CH_W-1:0]   channel;
        logic [SMP_W-1:0]  sample;
        logic [PIDX_W-1:0] point_index;
        logic [SMP_W-1:0]  point_value;
        logic              analog_enable;
        int                lead;
    } adc_item_t;

    typedef struct {
        logic [CH_W-1:0]          out_channel;
        logic [SMP_W-1:0]         raw_average;
        logic [SMP_W-1:0]         calibrated;
        logic signed [NORM_W-1:0] normalized;
        logic                     is_analog;
    } reading_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [FS_W-1:0] cfg_wdata;

    awc_item_if   item_bus ();
    awc_result_if result_bus ();

    adc_window_average_three_point_calibrate_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    int unsigned      scale_model;
    logic [SMP_W-1:0] window_hist [WIN_DEPTH];
    int unsigned      next_slot [CHANNELS];
    logic [SMP_W-1:0] cal_points [CHANNELS][3];
    logic             analog_on [CHANNELS];

    adc_item_t pending_items[$];
    reading_t  predicted_readings[$];

    adc_item_t cur_item;
    bit        item_held;
    bit        item_taken;
    bit        reading_taken;
    bit        send_calm;
    bit        sink_calm;
    int        sink_wait;
    int        quiet_cycles;
    int        mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned calibrate_avg(int unsigned raw, int unsigned lo,
                                                  int unsigned mid, int unsigned hi);
        int unsigned v;
        if (raw < lo)
            v = 0;
        else if (raw > hi)
            v = MAX_SCALE;
        else if (raw == mid)
            v = HALF_SCALE;
        else if (raw > mid)
            v = HALF_SCALE + (raw - mid) * HALF_SCALE / (hi - mid);
        else
            v = (raw - lo) * HALF_SCALE / (mid - lo);
        if (v > MAX_SCALE)
            v = MAX_SCALE;
        return v;
    endfunction

    function automatic logic signed [NORM_W-1:0] deflection(int unsigned cal);
        int unsigned mag;
        bit          neg;
        neg = cal < HALF_SCALE;
        mag = neg ? HALF_SCALE - cal : cal - HALF_SCALE;
        mag = mag * scale_model / HALF_SCALE;
        if (mag > NORM_MAX)
            mag = NORM_MAX;
        return neg ? NORM_W'(-int'(mag)) : NORM_W'(mag);
    endfunction

    function automatic void predict_reading(adc_item_t it);
        int unsigned ch;
        int unsigned sum;
        int unsigned cal;
        int          i;
        reading_t    r;
        ch = it.channel;
        if (ch >= CHANNELS)
            return;
        if (it.action == ACT_CAL_WRITE)
        begin
            // unused point index drops the whole write, flag too
            if (it.point_index == PT_NONE)
                return;
            cal_points[ch][it.point_index] = it.point_value;
            analog_on[ch] = it.analog_enable;
            return;
        end
        window_hist[ch * WINDOW + next_slot[ch]] = it.sample;
        next_slot[ch] = (next_slot[ch] + 1) % WINDOW;
        sum = 0;
        for (i = 0; i < WINDOW; i++)
            sum += window_hist[ch * WINDOW + i];
        cal = 0;
        r.out_channel = it.channel;
        r.raw_average = SMP_W'(sum / WINDOW);
        r.is_analog   = analog_on[ch];
        r.normalized  = '0;
        if (analog_on[ch])
        begin
            cal = calibrate_avg(sum / WINDOW, cal_points[ch][PT_LO], cal_points[ch][PT_MID],
                                cal_points[ch][PT_HI]);
            r.normalized = deflection(cal);
        end
        r.calibrated = SMP_W'(cal);
        predicted_readings.push_back(r);
    endfunction

    function automatic void queue_item(logic act, int ch, int smp, int pidx, int pval, bit aen);
        adc_item_t it;
        it.action        = act;
        it.channel       = CH_W'(ch);
        it.sample        = SMP_W'(smp);
        it.point_index   = PIDX_W'(pidx);
        it.point_value   = SMP_W'(pval);
        it.analog_enable = aen;
        it.lead          = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        pending_items.push_back(it);
    endfunction

    function automatic void queue_sample(int ch, int smp);
        queue_item(ACT_SAMPLE, ch, smp, $urandom_range(0, 3), $urandom_range(0, 4095),
                   1'($urandom_range(0, 1)));
    endfunction

    function automatic void queue_point(int ch, int pidx, int pval, bit aen);
        queue_item(ACT_CAL_WRITE, ch, $urandom_range(0, 4095), pidx, pval, aen);
    endfunction

    function automatic int clip12(int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // mostly sample bursts, with some calibration sets and noise in between
    function automatic void queue_random_phase(int count);
        int n;
        int k;
        int j;
        int ch;
        int level;
        int lo;
        int mid;
        int hi;
        int pidx;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 7) == 0)
                send_calm = !send_calm;
            ch    = $urandom_range(0, CHANNELS - 1);
            level = $urandom_range(0, 4095);
            case ($urandom_range(0, 9))
                0:
                begin
                    ch   = $urandom_range(0, 15);
                    pidx = $urandom_range(0, 3);
                    queue_item(1'($urandom_range(0, 1)), ch, $urandom_range(0, 4095), pidx,
                               $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
                    if (ch < CHANNELS && !(pending_items[$].action == ACT_CAL_WRITE
                                           && pidx == PT_NONE))
                        n++;
                end
                1, 2:
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        lo  = $urandom_range(0, 4095);
                        mid = $urandom_range(0, 4095);
                        hi  = $urandom_range(0, 4095);
                    end
                    else
                    begin
                        lo  = clip12(level - $urandom_range(0, 1500));
                        hi  = clip12(level + $urandom_range(0, 1500));
                        mid = $urandom_range(lo, hi);
                    end
                    queue_point(ch, PT_LO, lo, 1'b1);
                    queue_point(ch, PT_HI, hi, 1'b1);
                    queue_point(ch, PT_MID, mid, $urandom_range(0, 5) != 0);
                    n += 3;
                end
                default:
                begin
                    k = $urandom_range(4, 14);
                    for (j = 0; j < k; j++)
                    begin
                        case ($urandom_range(0, 15))
                            0:       queue_sample(ch, 0);
                            1:       queue_sample(ch, 4095);
                            default: queue_sample(ch, clip12(level + $urandom_range(0, 400)
                                                             - 200));
                        endcase
                    end
                    n += k;
                end
            endcase
        end
    endfunction

    task automatic write_scale(int unsigned value);
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= FS_W'(value);
        scale_model = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || item_held || predicted_readings.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // item accepted: update predictor
    always @(posedge clk)
    begin : item_accept
        if (rst_n && item_bus.valid && item_bus.ready)
        begin
            predict_reading(cur_item);
            item_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : item_driver
        if (item_taken)
        begin
            item_taken = 1'b0;
            item_held  = 1'b0;
        end
        if (rst_n && !item_held && pending_items.size() > 0)
        begin
            if (pending_items[0].lead > 0)
                pending_items[0].lead--;
            else
            begin
                cur_item  = pending_items.pop_front();
                item_held = 1'b1;
            end
        end
        item_bus.valid <= item_held;
        if (item_held)
        begin
            item_bus.action        <= cur_item.action;
            item_bus.channel       <= cur_item.channel;
            item_bus.sample        <= cur_item.sample;
            item_bus.point_index   <= cur_item.point_index;
            item_bus.point_value   <= cur_item.point_value;
            item_bus.analog_enable <= cur_item.analog_enable;
        end
    end

    always @(posedge clk)
    begin : reading_check
        reading_t got;
        reading_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            reading_taken   = 1'b1;
            got.out_channel = result_bus.out_channel;
            got.raw_average = result_bus.raw_average;
            got.calibrated  = result_bus.calibrated;
            got.normalized  = result_bus.normalized;
            got.is_analog   = result_bus.is_analog;
            if (predicted_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected reading ch %0d avg %0d cal %0d norm %0d an %0b",
                             $realtime, got.out_channel, got.raw_average, got.calibrated,
                             got.normalized, got.is_analog);
            end
            else
            begin
                want = predicted_readings.pop_front();
                if (got.out_channel !== want.out_channel || got.raw_average !== want.raw_average
                    || got.calibrated !== want.calibrated || got.normalized !== want.normalized
                    || got.is_analog !== want.is_analog)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: reading mismatch: expected ch %0d avg %0d cal %0d %s",
                                 $realtime, want.out_channel, want.raw_average,
                                 want.calibrated, "");
                        $display("    expected norm %0d analog %0b", want.normalized,
                                 want.is_analog);
                        $display("    got ch %0d avg %0d cal %0d norm %0d analog %0b",
                                 got.out_channel, got.raw_average, got.calibrated,
                                 got.normalized, got.is_analog);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : reading_sink
        if (reading_taken)
        begin
            reading_taken = 1'b0;
            if ($urandom_range(0, 47) == 0)
                sink_calm = !sink_calm;
            sink_wait = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (sink_wait > 0)
        begin
            sink_wait--;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : watchdog
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned scales[4];
        int          p;
        int          i;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        item_bus.valid         = 1'b0;
        item_bus.action        = ACT_SAMPLE;
        item_bus.channel       = '0;
        item_bus.sample        = '0;
        item_bus.point_index   = PT_LO;
        item_bus.point_value   = '0;
        item_bus.analog_enable = 1'b0;
        result_bus.ready       = 1'b0;
        scale_model            = FS_RESET;
        for (i = 0; i < WIN_DEPTH; i++)
            window_hist[i] = '0;
        for (i = 0; i < CHANNELS; i++)
        begin
            next_slot[i]           = 0;
            analog_on[i]           = 1'b0;
            cal_points[i][PT_LO]   = '0;
            cal_points[i][PT_MID]  = '0;
            cal_points[i][PT_HI]   = '0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, full_scale left at its reset value
        queue_sample(0, 4095);
        queue_sample(0, 0);
        queue_sample(11, 1000);
        queue_sample(15, 4095);
        queue_point(15, PT_LO, 100, 1'b1);
        queue_point(1, PT_NONE, 100, 1'b1);
        queue_sample(1, 1234);
        queue_point(2, PT_LO, 10, 1'b1);
        queue_point(2, PT_MID, 100, 1'b1);
        queue_point(2, PT_HI, 300, 1'b1);
        queue_sample(2, 50);      // below the low point
        queue_sample(2, 950);     // average lands on the centre
        queue_sample(2, 2000);    // average at the high point: overshoot saturates
        queue_sample(2, 4095);    // above the high point
        queue_point(3, PT_LO, 0, 1'b1);
        queue_point(3, PT_MID, 300, 1'b1);
        queue_point(3, PT_HI, 400, 1'b1);
        queue_sample(3, 1500);    // lower segment
        queue_sample(3, 2000);    // upper segment
        queue_point(4, PT_LO, 300, 1'b1);
        queue_point(4, PT_MID, 100, 1'b1);
        queue_point(4, PT_HI, 200, 1'b1);
        queue_sample(4, 2500);
        queue_sample(4, 1000);
        queue_point(2, PT_HI, 300, 1'b0);
        queue_sample(2, 0);
        queue_point(10, PT_HI, 4095, 1'b1);
        queue_sample(10, 4095);
        drain();

        scales[0] = NORM_MAX;
        scales[1] = 1;
        scales[2] = $urandom_range(2, NORM_MAX - 1);
        scales[3] = FS_RESET;
        for (p = 0; p < 4; p++)
        begin
            write_scale(scales[p]);
            queue_random_phase(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0 && predicted_readings.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
